// ===== src/edmb_pkg.sv =====
// Shared constants and types for the error diffusion dither and mask blend block.
package edmb_pkg;

   // Configuration port.
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
   localparam logic [CSR_W-1:0] LINE_WIDTH_RESET   = 11'd640;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 11'd360;

   // Frame geometry.
   localparam int ROW_W      = 10;
   localparam int MAX_HEIGHT = 1024;

   // Stream payload widths.
   localparam int PIX_W      = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Position flags that travel with a pixel from the position tracker.
   typedef struct packed {
      logic first_row;
      logic last_col;
      logic last_row;
   } pos_flags_type;

endpackage

// ===== src/edmb_pos.sv =====
// Configuration registers and raster position tracking of the incoming pixels.
module edmb_pos #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [edmb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [edmb_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                 accept,
   input  logic                                 frame_start,
   output logic [$clog2(MAX_WIDTH)-1:0]         x,
   output edmb_pkg::pos_flags_type              flags
);
   import edmb_pkg::*;

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int LW  = (CW > CSR_W) ? CW : CSR_W;
   localparam int HW  = ROW_W + 1;

   logic [CSR_W-1:0] line_width_ff, line_width_in;
   logic [CSR_W-1:0] frame_height_ff, frame_height_in;
   logic [XW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [LW-1:0]    w_raw, w_eff;
   logic [HW-1:0]    h_raw, h_eff;
   logic [ROW_W-1:0] y;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LINE_WIDTH:   line_width_in   = csr_wdata;
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata;
         endcase
      end
   end

   // Registers are used clamped to their legal range.
   always_comb begin
      w_raw = LW'(line_width_ff);
      if (w_raw == '0) begin
         w_eff = LW'(1);
      end else if (w_raw > LW'(MAX_WIDTH)) begin
         w_eff = LW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      h_raw = HW'(frame_height_ff);
      if (h_raw == '0) begin
         h_eff = HW'(1);
      end else if (h_raw > HW'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = h_raw;
      end
   end

   always_comb begin
      x               = frame_start ? '0 : col_ff;
      y               = frame_start ? '0 : row_ff;
      flags.first_row = (y == '0);
      flags.last_col  = ((LW'(x) + LW'(1)) >= w_eff);
      flags.last_row  = ((HW'(y) + HW'(1)) >= h_eff);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = flags.last_row ? '0 : y + ROW_W'(1);
         end else begin
            col_in = x + XW'(1);
            row_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

endmodule

// ===== src/edmb_chan.sv =====
// Threshold and error diffusion arithmetic for one color channel of one pixel.
module edmb_chan #(
   parameter int ERROR_FRACTION_BITS = 4
) (
   input  logic [edmb_pkg::PIX_W-1:0]             bg,
   input  logic                                   restart,
   input  logic                                   last_col,
   input  logic signed [ERROR_FRACTION_BITS+8:0]  right_err,
   input  logic signed [ERROR_FRACTION_BITS+8:0]  above_err,
   input  logic signed [ERROR_FRACTION_BITS+8:0]  pend0_err,
   input  logic signed [ERROR_FRACTION_BITS+8:0]  pend1_err,
   output logic                                   bit_on,
   output logic signed [ERROR_FRACTION_BITS+8:0]  right_next,
   output logic signed [ERROR_FRACTION_BITS+8:0]  below_left,
   output logic signed [ERROR_FRACTION_BITS+8:0]  below_here,
   output logic signed [ERROR_FRACTION_BITS+8:0]  pend0_next,
   output logic signed [ERROR_FRACTION_BITS+8:0]  pend1_next
);
   import edmb_pkg::*;

   localparam int F  = ERROR_FRACTION_BITS;
   localparam int EW = F + 9;
   localparam int VW = EW + 2;
   localparam int PW = VW + 3;
   localparam int SW = PW + 1;
   localparam logic signed [VW-1:0] THRESHOLD = VW'(255 * (1 << (F - 1)));
   localparam logic signed [VW-1:0] FULL      = VW'(255 * (1 << F));
   localparam logic signed [EW-1:0] ERR_MAX   = EW'((1 << (EW - 1)) - 1);
   localparam logic signed [EW-1:0] ERR_MIN   = -ERR_MAX - EW'(1);

   function automatic logic signed [EW-1:0] sat_err(input logic signed [SW-1:0] v);
      logic signed [EW-1:0] r;
      if (v > SW'(ERR_MAX)) begin
         r = ERR_MAX;
      end else if (v < SW'(ERR_MIN)) begin
         r = ERR_MIN;
      end else begin
         r = EW'(v);
      end
      return r;
   endfunction

   logic signed [EW-1:0] right_use, pend0_use, pend1_use;
   logic signed [VW-1:0] value, err;
   logic signed [PW-1:0] err_w, share7, share5, share3, share1;

   always_comb begin
      // A frame start wipes the errors carried along the row.
      right_use = restart ? '0 : right_err;
      pend0_use = restart ? '0 : pend0_err;
      pend1_use = restart ? '0 : pend1_err;

      value  = $signed({{(VW - PIX_W - F){1'b0}}, bg, {F{1'b0}}})
               + VW'(right_use) + VW'(above_err);
      bit_on = (value >= THRESHOLD);
      err    = bit_on ? value - FULL : value;

      // Weighted shares, each floored by an arithmetic shift of four.
      err_w  = PW'(err);
      share7 = ((err_w <<< 3) - err_w) >>> 4;
      share5 = ((err_w <<< 2) + err_w) >>> 4;
      share3 = ((err_w <<< 1) + err_w) >>> 4;
      share1 = err_w >>> 4;

      right_next = last_col ? '0 : sat_err(SW'(share7));
      below_left = sat_err(SW'(pend0_use) + SW'(share3));
      below_here = sat_err(SW'(pend1_use) + SW'(share5));
      pend0_next = last_col ? '0 : below_here;
      pend1_next = last_col ? '0 : sat_err(SW'(share1));
   end

endmodule

// ===== src/edmb_line_buf.sv =====
// Line buffer of errors for the next row, with a held write, fill count and read forwarding.
module edmb_line_buf #(
   parameter int MAX_WIDTH = 1024,
   parameter int DATA_W    = 39
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic                          rd_zero,
   output logic [DATA_W-1:0]             rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]             wr_data,
   input  logic                          hold_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  hold_addr,
   input  logic [DATA_W-1:0]             hold_data
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int FW = $clog2(MAX_WIDTH + 1);

   logic [DATA_W-1:0] mem [MAX_WIDTH];
   logic [DATA_W-1:0] mem_q_ff;

   logic              hold_valid_ff, hold_valid_in;
   logic [XW-1:0]     hold_addr_ff, hold_addr_in;
   logic [DATA_W-1:0] hold_data_ff, hold_data_in;
   logic [FW-1:0]     fill_ff, fill_in;

   logic              use_fwd_ff, use_fwd_in;
   logic [DATA_W-1:0] fwd_data_ff, fwd_data_in;

   logic              port_we;
   logic [XW-1:0]     port_addr;
   logic [DATA_W-1:0] port_data;
   logic [FW-1:0]     port_end, hold_end;

   // The single write port serves a direct write first and drains the held entry otherwise.
   always_comb begin
      port_we   = wr_en || hold_valid_ff;
      port_addr = wr_en ? wr_addr : hold_addr_ff;
      port_data = wr_en ? wr_data : hold_data_ff;

      hold_valid_in = hold_valid_ff && wr_en;
      hold_addr_in  = hold_addr_ff;
      hold_data_in  = hold_data_ff;
      if (hold_en) begin
         hold_valid_in = 1'b1;
         hold_addr_in  = hold_addr;
         hold_data_in  = hold_data;
      end
   end

   // Written entries always form a prefix of the row, so a count marks them.
   always_comb begin
      port_end = FW'(port_addr) + FW'(1);
      hold_end = FW'(hold_addr) + FW'(1);
      fill_in  = fill_ff;
      if (port_we && (port_end > fill_in)) begin
         fill_in = port_end;
      end
      if (hold_en && (hold_end > fill_in)) begin
         fill_in = hold_end;
      end
   end

   always_comb begin
      use_fwd_in  = use_fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (rd_en) begin
         use_fwd_in  = 1'b1;
         fwd_data_in = '0;
         priority if (rd_zero || (FW'(rd_addr) >= fill_in)) begin
            fwd_data_in = '0;
         end else if (port_we && (port_addr == rd_addr)) begin
            fwd_data_in = port_data;
         end else if (hold_valid_in && (hold_addr_in == rd_addr)) begin
            fwd_data_in = hold_data_in;
         end else begin
            use_fwd_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         fill_ff       <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_addr_ff <= hold_addr_in;
      hold_data_ff <= hold_data_in;
      use_fwd_ff   <= use_fwd_in;
      fwd_data_ff  <= fwd_data_in;
   end

   assign rd_data = use_fwd_ff ? fwd_data_ff : mem_q_ff;

endmodule

// ===== src/error_diffusion_dither_mask_blend.sv =====
// Top level of the Floyd-Steinberg dither and multiply blend of a raster pixel stream.
//
// Each input beat carries one pixel pair in raster order: a foreground RGB sample and a
// background RGB sample, with tuser set on the first pixel of a frame. Every background
// channel is dithered to 0 or 255 by Floyd-Steinberg error diffusion (7/16 right, 3/16
// below left, 5/16 below, 1/16 below right, each share floored, errors held with
// ERROR_FRACTION_BITS fraction bits and saturated). Shares that would leave the image are
// dropped. Each output channel is the foreground sample where the dithered bit is set and
// zero where it is clear; the three bits also come out, and tlast marks the last pixel of
// the frame. The block takes one beat per clock while the result side is not stalling;
// that rate is set by the right-hand error, which one pixel hands to the next through a
// single stage of add, compare and shift-add logic. The row-to-row errors live in a
// MAX_WIDTH-entry line buffer with one write and one read port; its read is issued as
// the beat is accepted, so the data is ready when the pixel is processed. No clearing
// pass is needed after reset. Line width and frame height must be written through the
// csr port while the stream is idle, which the block does not enforce; they are used
// clamped to 1..MAX_WIDTH and 1..1024.
module error_diffusion_dither_mask_blend #(
   parameter int MAX_WIDTH           = 1024,
   parameter int ERROR_FRACTION_BITS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration write port.
   input  logic                                 csr_we,
   input  logic [edmb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [edmb_pkg::CSR_W-1:0]           csr_wdata,
   // Pixel input stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, from bit 0 up
   input  logic [edmb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // frame_start
   input  logic                                 req_tuser,
   // Result stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_red, out_green, out_blue, dither_bits, from bit 0 up, then zero fill
   output logic [edmb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // frame_end
   output logic                                 rsp_tlast
);
   import edmb_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int EW = ERROR_FRACTION_BITS + 9;
   localparam int DW = 3 * EW;
   localparam int OUT_W = 3 * PIX_W + 3;

   logic          accept, s1_adv;
   logic [XW-1:0] pos_x;
   pos_flags_type pos_flags;

   // Pixel register: the accepted beat waits here for its line buffer data.
   logic                  s1_valid_ff, s1_valid_in;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic                  s1_start_ff;
   logic [XW-1:0]         s1_x_ff;
   pos_flags_type         s1_flags_ff;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]      out_data_ff;
   logic                  out_last_ff;

   // Errors carried along the row.
   logic signed [EW-1:0]  right_ff [3];
   logic signed [EW-1:0]  pend0_ff [3];
   logic signed [EW-1:0]  pend1_ff [3];
   logic signed [EW-1:0]  right_in [3];
   logic signed [EW-1:0]  pend0_in [3];
   logic signed [EW-1:0]  pend1_in [3];
   logic signed [EW-1:0]  below_left [3];
   logic signed [EW-1:0]  below_here [3];

   logic [DW-1:0]         above_word, left_word, here_word;
   logic [2:0]            bits;
   logic [OUT_W-1:0]      result;

   logic                  lb_wr_en, lb_hold_en, here_direct;
   logic [XW-1:0]         lb_wr_addr;
   logic [DW-1:0]         lb_wr_data;

   // The pixel register advances whenever the result register is free or being drained.
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   edmb_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .frame_start (req_tuser),
      .x           (pos_x),
      .flags       (pos_flags)
   );

   // The below error of the last column goes straight in on a one-pixel row; otherwise it
   // is held while the port writes the column to its left.
   always_comb begin
      here_direct = s1_flags_ff.last_col && (s1_x_ff == '0);
      lb_wr_en    = s1_adv && ((s1_x_ff != '0) || s1_flags_ff.last_col);
      lb_wr_addr  = here_direct ? s1_x_ff : s1_x_ff - XW'(1);
      lb_wr_data  = here_direct ? here_word : left_word;
      lb_hold_en  = s1_adv && s1_flags_ff.last_col && (s1_x_ff != '0);
   end

   edmb_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .DATA_W    (DW)
   ) u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (pos_x),
      .rd_zero   (pos_flags.first_row),
      .rd_data   (above_word),
      .wr_en     (lb_wr_en),
      .wr_addr   (lb_wr_addr),
      .wr_data   (lb_wr_data),
      .hold_en   (lb_hold_en),
      .hold_addr (s1_x_ff),
      .hold_data (here_word)
   );

   for (genvar c = 0; c < 3; c++) begin : g_chan
      edmb_chan #(
         .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
      ) u_chan (
         .bg         (s1_data_ff[(3 + c) * PIX_W +: PIX_W]),
         .restart    (s1_start_ff),
         .last_col   (s1_flags_ff.last_col),
         .right_err  (right_ff[c]),
         .above_err  ($signed(above_word[c * EW +: EW])),
         .pend0_err  (pend0_ff[c]),
         .pend1_err  (pend1_ff[c]),
         .bit_on     (bits[c]),
         .right_next (right_in[c]),
         .below_left (below_left[c]),
         .below_here (below_here[c]),
         .pend0_next (pend0_in[c]),
         .pend1_next (pend1_in[c])
      );
      assign left_word[c * EW +: EW] = below_left[c];
      assign here_word[c * EW +: EW] = below_here[c];
      assign result[c * PIX_W +: PIX_W] = s1_data_ff[c * PIX_W +: PIX_W] & {PIX_W{bits[c]}};
   end
   assign result[OUT_W-1 -: 3] = bits;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            right_ff[c] <= '0;
            pend0_ff[c] <= '0;
            pend1_ff[c] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            for (int c = 0; c < 3; c++) begin
               right_ff[c] <= right_in[c];
               pend0_ff[c] <= pend0_in[c];
               pend1_ff[c] <= pend1_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
         s1_x_ff     <= pos_x;
         s1_flags_ff <= pos_flags;
      end
      if (s1_adv) begin
         out_data_ff <= result;
         out_last_ff <= s1_flags_ff.last_col && s1_flags_ff.last_row;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== verif/edmb_checker.sv =====
`timescale 1ns / 1ps
// Checker for the dither and mask blend block: predicts every result beat and compares it.
module edmb_checker #(
   parameter int MAX_WIDTH           = 1024,
   parameter int ERROR_FRACTION_BITS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [edmb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [edmb_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [edmb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [edmb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   output int                                error_count,
   output int                                pending_count,
   output int                                beats_checked
);
   import edmb_pkg::*;

   localparam int ERR_W       = 9 + ERROR_FRACTION_BITS;
   localparam int ERR_MAX     = (1 << (ERR_W - 1)) - 1;
   localparam int ERR_MIN     = -ERR_MAX - 1;
   localparam int COL_W       = $clog2(MAX_WIDTH);

   typedef logic signed [ERR_W-1:0] diff_err_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [2:0]       bits;
      logic             frame_end;
   } blend_result_type;

   logic [CSR_W-1:0] width_reg;
   logic [CSR_W-1:0] height_reg;
   logic [COL_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   diff_err_type     below_errs [MAX_WIDTH][3];
   diff_err_type     right_err [3];
   diff_err_type     pend_err [2][3];
   blend_result_type blend_q [$];
   int               mismatch_total = 0;
   int               beats_seen = 0;

   function automatic int saturate(input int v);
      if (v > ERR_MAX) return ERR_MAX;
      if (v < ERR_MIN) return ERR_MIN;
      return v;
   endfunction

   // An arithmetic shift of a signed int floors, as the hardware does.
   function automatic int floor16(input int v);
      return v >>> 4;
   endfunction

   task automatic clear_model();
      int i, c;
      width_reg  = LINE_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      col_pos    = '0;
      row_pos    = '0;
      for (i = 0; i < MAX_WIDTH; i++)
         for (c = 0; c < 3; c++)
            below_errs[i][c] = '0;
      for (c = 0; c < 3; c++) begin
         right_err[c]   = '0;
         pend_err[0][c] = '0;
         pend_err[1][c] = '0;
      end
      blend_q.delete();
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_total++;
      $display("%0t ns mismatch: %s", $realtime, msg);
   endtask

   // Dithers one pixel pair, updates the diffusion state and queues the blended result.
   task automatic predict_pixel(input logic [REQ_DATA_W-1:0] d, input logic start);
      int               w, h, x, y, c, v, e, above, p0, thr, full;
      logic             last_col, last_row;
      logic [2:0]       bits;
      logic [7:0]       fg [3];
      blend_result_type r;
      w = width_reg;
      h = height_reg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      if (start) begin
         col_pos = '0;
         row_pos = '0;
         for (c = 0; c < 3; c++) begin
            right_err[c]   = '0;
            pend_err[0][c] = '0;
            pend_err[1][c] = '0;
         end
      end
      x        = int'(col_pos) % MAX_WIDTH;
      y        = int'(row_pos);
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);
      thr      = 255 << (ERROR_FRACTION_BITS - 1);
      full     = 255 << ERROR_FRACTION_BITS;
      bits     = '0;
      for (c = 0; c < 3; c++) begin
         fg[c] = d[8*c +: 8];
         above = (y == 0) ? 0 : int'(below_errs[x][c]);
         v     = (int'(d[24 + 8*c +: 8]) << ERROR_FRACTION_BITS) + int'(right_err[c]) + above;
         bits[c] = (v >= thr);
         e = v - (bits[c] ? full : 0);
         right_err[c] = last_col ? '0 : diff_err_type'(saturate(floor16(e * 7)));
         if (x > 0)
            below_errs[x-1][c] =
               diff_err_type'(saturate(int'(pend_err[0][c]) + floor16(e * 3)));
         p0 = saturate(int'(pend_err[1][c]) + floor16(e * 5));
         if (last_col) begin
            below_errs[x][c] = diff_err_type'(p0);
            pend_err[0][c]   = '0;
            pend_err[1][c]   = '0;
         end else begin
            pend_err[0][c] = diff_err_type'(p0);
            pend_err[1][c] = diff_err_type'(saturate(floor16(e)));
         end
      end
      r.red       = bits[0] ? fg[0] : 8'd0;
      r.green     = bits[1] ? fg[1] : 8'd0;
      r.blue      = bits[2] ? fg[2] : 8'd0;
      r.bits      = bits;
      r.frame_end = last_col && last_row;
      blend_q.push_back(r);
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : ROW_W'(y + 1);
      end else begin
         col_pos = COL_W'(x + 1);
      end
   endtask

   task automatic check_result();
      blend_result_type want;
      if (blend_q.size() == 0) begin
         report_mismatch($sformatf("result beat %0d arrived with no pixel waiting", beats_seen));
         beats_seen++;
         return;
      end
      want = blend_q.pop_front();
      if (rsp_tdata[7:0] !== want.red)
         report_mismatch($sformatf("beat %0d out_red got %0d want %0d",
                                   beats_seen, rsp_tdata[7:0], want.red));
      if (rsp_tdata[15:8] !== want.green)
         report_mismatch($sformatf("beat %0d out_green got %0d want %0d",
                                   beats_seen, rsp_tdata[15:8], want.green));
      if (rsp_tdata[23:16] !== want.blue)
         report_mismatch($sformatf("beat %0d out_blue got %0d want %0d",
                                   beats_seen, rsp_tdata[23:16], want.blue));
      if (rsp_tdata[26:24] !== want.bits)
         report_mismatch($sformatf("beat %0d dither_bits got %b want %b",
                                   beats_seen, rsp_tdata[26:24], want.bits));
      if (rsp_tdata[RSP_DATA_W-1:27] !== '0)
         report_mismatch($sformatf("beat %0d fill bits got %b want zero",
                                   beats_seen, rsp_tdata[RSP_DATA_W-1:27]));
      if (rsp_tlast !== want.frame_end)
         report_mismatch($sformatf("beat %0d frame_end got %b want %b",
                                   beats_seen, rsp_tlast, want.frame_end));
      beats_seen++;
   endtask

   // Prediction comes first so that a result leaving on its own beat's edge still matches.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (req_tvalid && req_tready)
            predict_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (csr_we) begin
            if (csr_index == REG_LINE_WIDTH)
               width_reg = csr_wdata;
            else if (csr_index == REG_FRAME_HEIGHT)
               height_reg = csr_wdata;
         end
      end
      error_count   <= mismatch_total;
      pending_count <= blend_q.size();
      beats_checked <= beats_seen;
   end

endmodule

// ===== verif/error_diffusion_dither_mask_blend_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the dither and mask blend block: stimulus, back pressure and verdict.
module error_diffusion_dither_mask_blend_tb;
   import edmb_pkg::*;

   localparam int MAX_WIDTH           = 1024;
   localparam int ERROR_FRACTION_BITS = 4;
   // The limit leaves a wide margin over the slowest legal run.
   localparam int CYCLE_LIMIT         = 400000;
   // Idle cycles waited once every result is in; they cover the block's registers easily.
   localparam int DRAIN_CYCLES        = 16;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_LONG_STALL
   } ready_mode_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_W-1:0]        csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;

   int error_count;
   int pending_count;
   int beats_checked;

   int cycle_count    = 0;
   int pixels_sent    = 0;
   int settings_count = 0;
   int burst_left     = 1;
   int gap_left       = 0;
   bit driving        = 1'b0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             stall_left = 0;

   error_diffusion_dither_mask_blend #(
      .MAX_WIDTH           (MAX_WIDTH),
      .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The checker sees exactly what the block sees and keeps its own copy of the
   // geometry registers, so it needs nothing from the stimulus side.
   edmb_checker #(
      .MAX_WIDTH           (MAX_WIDTH),
      .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count),
      .beats_checked (beats_checked)
   );

   always #4 clock = ~clock;

   // Watchdog. A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side back pressure. The mode changes at random intervals, so stalls land
   // on every phase of the pipeline and there are also long stretches with no stall.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(100, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      unique case (ready_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         READY_PERIODIC: begin
            rsp_tready <= ((cycle_count % 5) < 2);
         end
         default: begin
            // Alternating runs of ready and stall of random length.
            if (stall_left == 0) begin
               rsp_tready <= ~rsp_tready;
               stall_left <= $urandom_range(1, 16);
            end else begin
               stall_left <= stall_left - 1;
            end
         end
      endcase
   end

   // Random samples lean on the extremes and on the neighborhood of the 127.5 threshold.
   function automatic logic [7:0] rand_bg();
      unique case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd127;
         3:       return 8'd128;
         4:       return 8'($urandom_range(118, 137));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] rand_fg();
      unique case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int clamp_size(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Offers one pixel beat and returns at the edge where it is taken. Within a burst
   // tvalid stays high from beat to beat; a gap lowers it at the accepting edge.
   task automatic send_pixel(input logic [7:0] fg_r, input logic [7:0] fg_g,
                             input logic [7:0] fg_b, input logic [7:0] bg_r,
                             input logic [7:0] bg_g, input logic [7:0] bg_b,
                             input logic start);
      if (gap_left > 0) begin
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {bg_b, bg_g, bg_r, fg_b, fg_g, fg_r};
      req_tuser  <= start;
      driving     = 1'b1;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 24);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            driving     = 1'b0;
         end
      end
   endtask

   // Stops offering beats and waits until every pixel has its result, plus the pipeline
   // latency, so that a register write cannot land on a pixel in flight.
   task automatic wait_idle();
      if (driving) begin
         req_tvalid <= 1'b0;
         driving     = 1'b0;
      end
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_geometry(input int w_reg, input int h_reg);
      wait_idle();
      write_reg(REG_LINE_WIDTH, CSR_W'(w_reg));
      write_reg(REG_FRAME_HEIGHT, CSR_W'(h_reg));
      settings_count++;
   endtask

   // Random frames for one geometry. Most frames are well formed, with tuser on their
   // first pixel; now and then the frame start is left out at a boundary, so the block has
   // to wrap by itself, or a stray frame start cuts a frame short.
   task automatic run_frames(input int w_reg, input int h_reg, input int count);
      int   frame_size, pos, k;
      logic start;
      set_geometry(w_reg, h_reg);
      frame_size = clamp_size(w_reg, MAX_WIDTH) * clamp_size(h_reg, MAX_HEIGHT);
      pos = 0;
      for (k = 0; k < count; k++) begin
         if (pos == 0 || pos >= frame_size) begin
            start = ($urandom_range(0, 7) != 0);
            pos   = 0;
         end else begin
            start = ($urandom_range(0, 39) == 0);
            if (start)
               pos = 0;
         end
         send_pixel(rand_fg(), rand_fg(), rand_fg(), rand_bg(), rand_bg(), rand_bg(), start);
         pos++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Two pixels run on the reset geometry without any frame start.
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 8'd127, 8'd128, 8'd255, 1'b0);

      // A full 3 by 2 frame with samples at both extremes and on either side of the
      // threshold, so errors of both signs reach right, below left, below and below right.
      set_geometry(3, 2);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd128, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd255, 8'd127, 8'd127, 8'd127, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 8'd127, 1'b0);
      send_pixel(8'd170, 8'd85, 8'd255, 8'd64, 8'd192, 8'd1, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 8'd254, 8'd2, 8'd200, 1'b0);

      // No frame start after the frame end: the block must open a clean frame itself.
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);

      // A frame start in the middle of a row throws away the errors gathered so far.
      send_pixel(8'd255, 8'd255, 8'd255, 8'd200, 8'd60, 8'd127, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd127, 8'd128, 8'd30, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd100, 8'd180, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd130, 8'd126, 8'd0, 1'b0);

      // Zero in both registers clamps to a single pixel frame, and the position left in
      // the middle of the second row now lies past both bounds.
      set_geometry(0, 0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd128, 8'd127, 8'd255, 1'b0);
      send_pixel(8'd99, 8'd255, 8'd1, 8'd255, 8'd255, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd127, 8'd0, 8'd200, 1'b1);

      // Random part. Small frames carry most of the traffic; the widest and tallest
      // settings, clamped from all ones, only see their first rows or columns.
      run_frames(1, 1, 60);
      run_frames(1, 7, 60);
      run_frames(2, 2, 80);
      run_frames(3, 4, 100);
      run_frames(7, 5, 150);
      run_frames(16, 8, 260);
      run_frames(33, 3, 200);
      run_frames(2047, 2, 150);
      run_frames(5, 2047, 120);
      run_frames(1024, 1024, 80);
      run_frames(11, 6, 160);

      wait_idle();
      $display("Compared %0d result beats from %0d pixel beats over %0d geometry settings,",
               beats_checked, pixels_sent, settings_count);
      $display("including clamped, shrunk and widest settings, under random back pressure.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
